// ----- hw/rtl/qslerp_pkg.sv -----
// qslerp_pkg: shared widths, constants, side-band word and arctangent table
// for the quaternion slerp pipeline; used by every cell and by the top level
package qslerp_pkg;

    localparam int COMP_W       = 16;     // Q2.14 component
    localparam int FRAC_W       = 17;     // Q1.16 fraction / Q0.16 threshold
    localparam int SQRT_W       = 17;     // bits of the sine-of-angle root
    localparam int ARG_W        = 34;     // sqrt argument and remainder
    localparam int ANG_W        = 20;     // CORDIC x, y, z in Q.16
    localparam int QW           = 33;     // quotient bits of the weight divide
    localparam int K_W          = 34;     // signed weight in Q.16
    localparam int ATAN_ENTRIES = 24;
    localparam int ONE_Q16      = 65536;
    localparam int CORDIC_GAIN  = 39797;
    localparam logic [FRAC_W-1:0] THR_RESET = 17'd65503;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [COMP_W:0]   t_comp_ext;
    typedef logic signed [ANG_W-1:0]  t_ang;

    // values that ride along the cell chains next to the working registers
    typedef struct packed {
        t_comp [3:0]          qa;
        t_comp_ext [3:0]      qb;
        logic [FRAC_W-1:0]    t;
        logic                 lin;
        logic [SQRT_W-1:0]    cmin;
        logic [SQRT_W-1:0]    s;
        t_ang                 z0;
        t_ang                 z1;
        logic                 neg0;
        logic                 neg1;
    } t_side;

    // round(atan(2^-i) * 65536)
    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/qslerp_in_if.sv -----
// qslerp_in_if: input channel, two quaternions and a fraction per word
// depends on nothing
interface qslerp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic [16:0]        t_fraction;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, t_fraction,
                    input ready);
    modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, t_fraction,
                    output ready);
endinterface

// ----- hw/rtl/qslerp_out_if.sv -----
// qslerp_out_if: output channel, one interpolated quaternion per word
// depends on nothing
interface qslerp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_w;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;

    modport source (output valid, r_w, r_x, r_y, r_z, input ready);
    modport sink   (input valid, r_w, r_x, r_y, r_z, output ready);
endinterface

// ----- hw/rtl/qslerp_sqrt_cell.sv -----
// qslerp_sqrt_cell: one bit of a pipelined restoring integer square root
// depends on qslerp_pkg
module qslerp_sqrt_cell #(
    parameter int BIT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [qslerp_pkg::ARG_W-1:0]  i_rem,
    input  logic [qslerp_pkg::SQRT_W-1:0] i_root,
    input  qslerp_pkg::t_side             i_side,
    output logic                          o_vld,
    output logic [qslerp_pkg::ARG_W-1:0]  o_rem,
    output logic [qslerp_pkg::SQRT_W-1:0] o_root,
    output qslerp_pkg::t_side             o_side
);
    import qslerp_pkg::*;

    localparam logic [ARG_W-1:0] SQ = ARG_W'(1) << (2 * BIT);

    logic              r_vld;
    logic [ARG_W-1:0]  r_rem, n_rem;
    logic [SQRT_W-1:0] r_root, n_root;
    t_side             r_side;
    logic [ARG_W-1:0]  inc;

    // try setting this root bit: (root + 2^b)^2 - root^2
    always_comb begin
        inc    = ({{(ARG_W-SQRT_W){1'b0}}, i_root} << (BIT + 1)) + SQ;
        n_rem  = i_rem;
        n_root = i_root;
        if (i_rem >= inc) begin
            n_rem       = i_rem - inc;
            n_root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

// ----- hw/rtl/qslerp_vec_cell.sv -----
// qslerp_vec_cell: one CORDIC vectoring iteration, accumulates the angle
// depends on qslerp_pkg
module qslerp_vec_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  qslerp_pkg::t_ang  i_x,
    input  qslerp_pkg::t_ang  i_y,
    input  qslerp_pkg::t_ang  i_z,
    input  qslerp_pkg::t_side i_side,
    output logic              o_vld,
    output qslerp_pkg::t_ang  o_x,
    output qslerp_pkg::t_ang  o_y,
    output qslerp_pkg::t_ang  o_z,
    output qslerp_pkg::t_side o_side
);
    import qslerp_pkg::*;

    localparam logic [4:0] TAB_IDX = 5'(IDX);

    logic  r_vld;
    t_ang  r_x, r_y, r_z, n_x, n_y, n_z;
    t_side r_side;
    t_ang  sx, sy, at;

    assign sx = i_y >>> IDX;
    assign sy = i_x >>> IDX;
    assign at = $signed({{(ANG_W-17){1'b0}}, atan_q16(TAB_IDX)});

    // rotate toward the x axis
    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + sx;
            n_y = i_y - sy;
            n_z = i_z + at;
        end else begin
            n_x = i_x - sx;
            n_y = i_y + sy;
            n_z = i_z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;
endmodule

// ----- hw/rtl/qslerp_rot_cell.sv -----
// qslerp_rot_cell: one CORDIC rotation iteration on two lanes (both sines)
// depends on qslerp_pkg
module qslerp_rot_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  qslerp_pkg::t_ang  i_x0,
    input  qslerp_pkg::t_ang  i_y0,
    input  qslerp_pkg::t_ang  i_z0,
    input  qslerp_pkg::t_ang  i_x1,
    input  qslerp_pkg::t_ang  i_y1,
    input  qslerp_pkg::t_ang  i_z1,
    input  qslerp_pkg::t_side i_side,
    output logic              o_vld,
    output qslerp_pkg::t_ang  o_x0,
    output qslerp_pkg::t_ang  o_y0,
    output qslerp_pkg::t_ang  o_z0,
    output qslerp_pkg::t_ang  o_x1,
    output qslerp_pkg::t_ang  o_y1,
    output qslerp_pkg::t_ang  o_z1,
    output qslerp_pkg::t_side o_side
);
    import qslerp_pkg::*;

    localparam logic [4:0] TAB_IDX = 5'(IDX);

    logic  r_vld;
    t_ang  r_x0, r_y0, r_z0, r_x1, r_y1, r_z1;
    t_ang  n_x0, n_y0, n_z0, n_x1, n_y1, n_z1;
    t_side r_side;
    t_ang  at;

    assign at = $signed({{(ANG_W-17){1'b0}}, atan_q16(TAB_IDX)});

    // lane 0: sin((1-t) angle)
    always_comb begin
        if (i_z0 >= 0) begin
            n_x0 = i_x0 - (i_y0 >>> IDX);
            n_y0 = i_y0 + (i_x0 >>> IDX);
            n_z0 = i_z0 - at;
        end else begin
            n_x0 = i_x0 + (i_y0 >>> IDX);
            n_y0 = i_y0 - (i_x0 >>> IDX);
            n_z0 = i_z0 + at;
        end
    end

    // lane 1: sin(t angle)
    always_comb begin
        if (i_z1 >= 0) begin
            n_x1 = i_x1 - (i_y1 >>> IDX);
            n_y1 = i_y1 + (i_x1 >>> IDX);
            n_z1 = i_z1 - at;
        end else begin
            n_x1 = i_x1 + (i_y1 >>> IDX);
            n_y1 = i_y1 - (i_x1 >>> IDX);
            n_z1 = i_z1 + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0   <= n_x0;
            r_y0   <= n_y0;
            r_z0   <= n_z0;
            r_x1   <= n_x1;
            r_y1   <= n_y1;
            r_z1   <= n_z1;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x0   = r_x0;
    assign o_y0   = r_y0;
    assign o_z0   = r_z0;
    assign o_x1   = r_x1;
    assign o_y1   = r_y1;
    assign o_z1   = r_z1;
    assign o_side = r_side;
endmodule

// ----- hw/rtl/qslerp_div_cell.sv -----
// qslerp_div_cell: one quotient bit of a restoring divide, two lanes by sin(angle)
// depends on qslerp_pkg
module qslerp_div_cell #(
    parameter int BIT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [qslerp_pkg::QW-1:0]     i_dvd0,
    input  logic [qslerp_pkg::QW-1:0]     i_dvd1,
    input  logic [qslerp_pkg::SQRT_W-1:0] i_rem0,
    input  logic [qslerp_pkg::SQRT_W-1:0] i_rem1,
    input  logic [qslerp_pkg::QW-1:0]     i_q0,
    input  logic [qslerp_pkg::QW-1:0]     i_q1,
    input  qslerp_pkg::t_side             i_side,
    output logic                          o_vld,
    output logic [qslerp_pkg::QW-1:0]     o_dvd0,
    output logic [qslerp_pkg::QW-1:0]     o_dvd1,
    output logic [qslerp_pkg::SQRT_W-1:0] o_rem0,
    output logic [qslerp_pkg::SQRT_W-1:0] o_rem1,
    output logic [qslerp_pkg::QW-1:0]     o_q0,
    output logic [qslerp_pkg::QW-1:0]     o_q1,
    output qslerp_pkg::t_side             o_side
);
    import qslerp_pkg::*;

    logic              r_vld;
    logic [QW-1:0]     r_dvd0, r_dvd1, r_q0, r_q1, n_q0, n_q1;
    logic [SQRT_W-1:0] r_rem0, r_rem1, n_rem0, n_rem1;
    t_side             r_side;
    logic [SQRT_W:0]   sh0, sh1, ds;

    // bring down the next dividend bit and subtract if it fits
    always_comb begin
        ds     = {1'b0, i_side.s};
        sh0    = {i_rem0, i_dvd0[BIT]};
        sh1    = {i_rem1, i_dvd1[BIT]};
        n_rem0 = sh0[SQRT_W-1:0];
        n_rem1 = sh1[SQRT_W-1:0];
        n_q0   = i_q0;
        n_q1   = i_q1;
        if (sh0 >= ds) begin
            n_rem0    = SQRT_W'(sh0 - ds);
            n_q0[BIT] = 1'b1;
        end
        if (sh1 >= ds) begin
            n_rem1    = SQRT_W'(sh1 - ds);
            n_q1[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd0 <= i_dvd0;
            r_dvd1 <= i_dvd1;
            r_rem0 <= n_rem0;
            r_rem1 <= n_rem1;
            r_q0   <= n_q0;
            r_q1   <= n_q1;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_dvd0 = r_dvd0;
    assign o_dvd1 = r_dvd1;
    assign o_rem0 = r_rem0;
    assign o_rem1 = r_rem1;
    assign o_q0   = r_q0;
    assign o_q1   = r_q1;
    assign o_side = r_side;
endmodule

// ----- hw/rtl/quaternion_slerp_unit.sv -----
// quaternion_slerp_unit: fixed-point quaternion slerp, fully pipelined
// depends on qslerp_pkg, qslerp_in_if, qslerp_out_if and the four cell modules
//
// Takes one word per cycle and returns one interpolated quaternion per word, in
// order. The chain holds 17 square-root cells, N vectoring cells and N two-lane
// rotation cells (N is CORDIC_STAGES, capped at ATAN_ENTRIES), 33 divider cells
// and nine setup and multiply stages. The whole chain advances together; when
// the output word is held and not taken, every stage holds and ready drops. The
// threshold register may be written whenever the pipeline is empty.
module quaternion_slerp_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    qslerp_in_if.sink                     i_in,
    qslerp_out_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [qslerp_pkg::FRAC_W-1:0] i_cfg_data
);
    import qslerp_pkg::*;

    localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic              en;
    logic [FRAC_W-1:0] r_thr;

    // global advance: the output register is free or being taken
    logic r_o_vld;
    assign en         = !r_o_vld || o_out.ready;
    assign i_in.ready = en;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // stage a: capture word, component products, fraction clamp
    logic                      r_a_vld;
    t_side                     r_a_side, n_a_side;
    logic signed [31:0]        r_a_p [4];
    logic signed [31:0]        n_a_p [4];
    t_comp                     in_a [4];
    t_comp                     in_b [4];

    assign in_a[0] = i_in.a_w;
    assign in_a[1] = i_in.a_x;
    assign in_a[2] = i_in.a_y;
    assign in_a[3] = i_in.a_z;
    assign in_b[0] = i_in.b_w;
    assign in_b[1] = i_in.b_x;
    assign in_b[2] = i_in.b_y;
    assign in_b[3] = i_in.b_z;

    always_comb begin
        n_a_side = '0;
        for (int i = 0; i < 4; i++) begin
            n_a_side.qa[i] = in_a[i];
            n_a_side.qb[i] = {in_b[i][COMP_W-1], in_b[i]};
            n_a_p[i]       = in_a[i] * in_b[i];
        end
        n_a_side.t = (i_in.t_fraction > FRAC_W'(ONE_Q16)) ? FRAC_W'(ONE_Q16)
                                                          : i_in.t_fraction;
    end

    // stage b: dot product, fold to positive side
    logic                r_b_vld;
    t_side               r_b_side, n_b_side;
    logic [20:0]         r_b_c, n_b_c;
    logic signed [33:0]  dot;
    logic [32:0]         dot_mag;

    always_comb begin
        dot = 34'(r_a_p[0]) + 34'(r_a_p[1]) + 34'(r_a_p[2]) + 34'(r_a_p[3]);
        n_b_side = r_a_side;
        dot_mag  = dot[32:0];
        if (dot < 0) begin
            dot_mag = 33'(-dot);
            for (int i = 0; i < 4; i++) begin
                n_b_side.qb[i] = -r_a_side.qb[i];
            end
        end
        n_b_c = dot_mag[32:12];
    end

    // stage c: clamp, sqrt argument and path select
    logic              r_c_vld;
    t_side             r_c_side, n_c_side;
    logic [ARG_W-1:0]  r_c_arg, n_c_arg;
    logic [33:0]       csq;

    always_comb begin
        n_c_side      = r_b_side;
        n_c_side.lin  = r_b_c > {4'b0, r_thr};
        n_c_side.cmin = (r_b_c > 21'(ONE_Q16)) ? SQRT_W'(ONE_Q16) : r_b_c[SQRT_W-1:0];
        csq           = 34'(n_c_side.cmin) * 34'(n_c_side.cmin);
        n_c_arg       = (ARG_W'(1) << 32) - ARG_W'(csq);
    end

    // square root chain
    logic              sq_vld  [SQRT_W+1];
    logic [ARG_W-1:0]  sq_rem  [SQRT_W+1];
    logic [SQRT_W-1:0] sq_root [SQRT_W+1];
    t_side             sq_side [SQRT_W+1];

    assign sq_vld[0]  = r_c_vld;
    assign sq_rem[0]  = r_c_arg;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_c_side;

    genvar g;
    generate
        for (g = 0; g < SQRT_W; g++) begin : g_sqrt
            qslerp_sqrt_cell #(.BIT(SQRT_W - 1 - g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_vld  (sq_vld[g]),
                .i_rem  (sq_rem[g]),
                .i_root (sq_root[g]),
                .i_side (sq_side[g]),
                .o_vld  (sq_vld[g+1]),
                .o_rem  (sq_rem[g+1]),
                .o_root (sq_root[g+1]),
                .o_side (sq_side[g+1])
            );
        end
    endgenerate

    // vectoring chain: angle from (cos, sin)
    logic  v_vld  [N+1];
    t_ang  v_x    [N+1];
    t_ang  v_y    [N+1];
    t_ang  v_z    [N+1];
    t_side v_side [N+1];
    t_side vs_in;

    always_comb begin
        vs_in   = sq_side[SQRT_W];
        vs_in.s = sq_root[SQRT_W];
    end
    assign v_side[0] = vs_in;
    assign v_vld[0]  = sq_vld[SQRT_W];
    assign v_x[0]    = $signed({{(ANG_W-SQRT_W){1'b0}}, sq_side[SQRT_W].cmin});
    assign v_y[0]    = $signed({{(ANG_W-SQRT_W){1'b0}}, sq_root[SQRT_W]});
    assign v_z[0]    = '0;

    generate
        for (g = 0; g < N; g++) begin : g_vec
            qslerp_vec_cell #(.IDX(g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_vld  (v_vld[g]),
                .i_x    (v_x[g]),
                .i_y    (v_y[g]),
                .i_z    (v_z[g]),
                .i_side (v_side[g]),
                .o_vld  (v_vld[g+1]),
                .o_x    (v_x[g+1]),
                .o_y    (v_y[g+1]),
                .o_z    (v_z[g+1]),
                .o_side (v_side[g+1])
            );
        end
    endgenerate

    // stage m: scale the angle by 1-t and t
    logic               r_m_vld;
    t_side              r_m_side, n_m_side;
    logic signed [38:0] m0, m1;

    always_comb begin
        m0       = 39'(v_z[N]) * $signed({22'b0, 17'(FRAC_W'(ONE_Q16) - v_side[N].t)});
        m1       = 39'(v_z[N]) * $signed({22'b0, v_side[N].t});
        n_m_side = v_side[N];
        n_m_side.z0 = ANG_W'(m0 >>> 16);
        n_m_side.z1 = ANG_W'(m1 >>> 16);
    end

    // rotation chain: both sines
    logic  ro_vld  [N+1];
    t_ang  ro_x0   [N+1];
    t_ang  ro_y0   [N+1];
    t_ang  ro_z0   [N+1];
    t_ang  ro_x1   [N+1];
    t_ang  ro_y1   [N+1];
    t_ang  ro_z1   [N+1];
    t_side ro_side [N+1];

    assign ro_vld[0]  = r_m_vld;
    assign ro_x0[0]   = ANG_W'(CORDIC_GAIN);
    assign ro_y0[0]   = '0;
    assign ro_z0[0]   = r_m_side.z0;
    assign ro_x1[0]   = ANG_W'(CORDIC_GAIN);
    assign ro_y1[0]   = '0;
    assign ro_z1[0]   = r_m_side.z1;
    assign ro_side[0] = r_m_side;

    generate
        for (g = 0; g < N; g++) begin : g_rot
            qslerp_rot_cell #(.IDX(g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_vld  (ro_vld[g]),
                .i_x0   (ro_x0[g]),
                .i_y0   (ro_y0[g]),
                .i_z0   (ro_z0[g]),
                .i_x1   (ro_x1[g]),
                .i_y1   (ro_y1[g]),
                .i_z1   (ro_z1[g]),
                .i_side (ro_side[g]),
                .o_vld  (ro_vld[g+1]),
                .o_x0   (ro_x0[g+1]),
                .o_y0   (ro_y0[g+1]),
                .o_z0   (ro_z0[g+1]),
                .o_x1   (ro_x1[g+1]),
                .o_y1   (ro_y1[g+1]),
                .o_z1   (ro_z1[g+1]),
                .o_side (ro_side[g+1])
            );
        end
    endgenerate

    // stage d: sine magnitudes as dividends
    logic          r_d_vld;
    t_side         r_d_side, n_d_side;
    logic [QW-1:0] r_d_dvd0, r_d_dvd1, n_d_dvd0, n_d_dvd1;
    t_ang          mag0, mag1;

    always_comb begin
        n_d_side      = ro_side[N];
        n_d_side.neg0 = ro_y0[N] < 0;
        n_d_side.neg1 = ro_y1[N] < 0;
        mag0          = n_d_side.neg0 ? -ro_y0[N] : ro_y0[N];
        mag1          = n_d_side.neg1 ? -ro_y1[N] : ro_y1[N];
        n_d_dvd0      = {mag0[SQRT_W-1:0], 16'b0};
        n_d_dvd1      = {mag1[SQRT_W-1:0], 16'b0};
    end

    // divider chain
    logic              dv_vld  [QW+1];
    logic [QW-1:0]     dv_dvd0 [QW+1];
    logic [QW-1:0]     dv_dvd1 [QW+1];
    logic [SQRT_W-1:0] dv_rem0 [QW+1];
    logic [SQRT_W-1:0] dv_rem1 [QW+1];
    logic [QW-1:0]     dv_q0   [QW+1];
    logic [QW-1:0]     dv_q1   [QW+1];
    t_side             dv_side [QW+1];

    assign dv_vld[0]  = r_d_vld;
    assign dv_dvd0[0] = r_d_dvd0;
    assign dv_dvd1[0] = r_d_dvd1;
    assign dv_rem0[0] = '0;
    assign dv_rem1[0] = '0;
    assign dv_q0[0]   = '0;
    assign dv_q1[0]   = '0;
    assign dv_side[0] = r_d_side;

    generate
        for (g = 0; g < QW; g++) begin : g_div
            qslerp_div_cell #(.BIT(QW - 1 - g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_vld  (dv_vld[g]),
                .i_dvd0 (dv_dvd0[g]),
                .i_dvd1 (dv_dvd1[g]),
                .i_rem0 (dv_rem0[g]),
                .i_rem1 (dv_rem1[g]),
                .i_q0   (dv_q0[g]),
                .i_q1   (dv_q1[g]),
                .i_side (dv_side[g]),
                .o_vld  (dv_vld[g+1]),
                .o_dvd0 (dv_dvd0[g+1]),
                .o_dvd1 (dv_dvd1[g+1]),
                .o_rem0 (dv_rem0[g+1]),
                .o_rem1 (dv_rem1[g+1]),
                .o_q0   (dv_q0[g+1]),
                .o_q1   (dv_q1[g+1]),
                .o_side (dv_side[g+1])
            );
        end
    endgenerate

    // stage k: signed weights, linear fallback
    logic                  r_k_vld;
    t_side                 r_k_side;
    logic signed [K_W-1:0] r_k0, r_k1, n_k0, n_k1;
    t_side                 ks;

    always_comb begin
        ks = dv_side[QW];
        if (ks.lin || (ks.s == '0)) begin
            n_k0 = $signed(K_W'(FRAC_W'(ONE_Q16) - ks.t));
            n_k1 = $signed(K_W'(ks.t));
        end else begin
            n_k0 = ks.neg0 ? -$signed({1'b0, dv_q0[QW]}) : $signed({1'b0, dv_q0[QW]});
            n_k1 = ks.neg1 ? -$signed({1'b0, dv_q1[QW]}) : $signed({1'b0, dv_q1[QW]});
        end
    end

    // stage p: partial products, weight split at bit 17
    logic               r_p_vld;
    logic signed [32:0] r_pha [4];
    logic signed [33:0] r_pla [4];
    logic signed [33:0] r_phb [4];
    logic signed [34:0] r_plb [4];
    logic signed [16:0] kh0, kh1;
    logic signed [17:0] kl0, kl1;

    assign kh0 = r_k0[K_W-1:17];
    assign kh1 = r_k1[K_W-1:17];
    assign kl0 = $signed({1'b0, r_k0[16:0]});
    assign kl1 = $signed({1'b0, r_k1[16:0]});

    // stage s: recombine
    logic               r_s_vld;
    logic signed [55:0] r_s_sum [4];

    // output register with saturation
    t_comp r_o_c [4];
    logic signed [55:0] sh [4];
    t_comp n_o_c [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sh[i] = r_s_sum[i] >>> 16;
            if (sh[i] > 56'sd32767) begin
                n_o_c[i] = 16'sh7fff;
            end else if (sh[i] < -56'sd32768) begin
                n_o_c[i] = 16'sh8000;
            end else begin
                n_o_c[i] = sh[i][COMP_W-1:0];
            end
        end
    end

    // valid bits of the non-cell stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_m_vld <= v_vld[N];
            r_d_vld <= ro_vld[N];
            r_k_vld <= dv_vld[QW];
            r_p_vld <= r_k_vld;
            r_s_vld <= r_p_vld;
            r_o_vld <= r_s_vld;
        end
    end

    // data of the non-cell stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= n_a_side;
            r_b_side <= n_b_side;
            r_b_c    <= n_b_c;
            r_c_side <= n_c_side;
            r_c_arg  <= n_c_arg;
            r_m_side <= n_m_side;
            r_d_side <= n_d_side;
            r_d_dvd0 <= n_d_dvd0;
            r_d_dvd1 <= n_d_dvd1;
            r_k_side <= ks;
            r_k0     <= n_k0;
            r_k1     <= n_k1;
            for (int i = 0; i < 4; i++) begin
                r_a_p[i]   <= n_a_p[i];
                r_pha[i]   <= r_k_side.qa[i] * kh0;
                r_pla[i]   <= r_k_side.qa[i] * kl0;
                r_phb[i]   <= r_k_side.qb[i] * kh1;
                r_plb[i]   <= r_k_side.qb[i] * kl1;
                r_s_sum[i] <= ((56'(r_pha[i]) + 56'(r_phb[i])) <<< 17)
                              + 56'(r_pla[i]) + 56'(r_plb[i]);
                r_o_c[i]   <= n_o_c[i];
            end
        end
    end

    assign o_out.valid = r_o_vld;
    assign o_out.r_w   = r_o_c[0];
    assign o_out.r_x   = r_o_c[1];
    assign o_out.r_y   = r_o_c[2];
    assign o_out.r_z   = r_o_c[3];
endmodule
